>>> sv/led_blink_pattern_sequencer_top_assert.svh
// Assertion macros for the LED blink pattern sequencer.
`ifndef LED_BLINK_PATTERN_SEQUENCER_TOP_ASSERT_SVH
`define LED_BLINK_PATTERN_SEQUENCER_TOP_ASSERT_SVH
`ifndef SYNTHESIS
// Same-cycle implication, disabled during reset.
`define LBPS_ASSERT_IMP(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("lbps: same-cycle implication failed");
// Next-cycle implication, disabled during reset.
`define LBPS_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("lbps: next-cycle implication failed");
`else
`define LBPS_ASSERT_IMP(label, clk, rst_n, ante, cons)
`define LBPS_ASSERT_NEXT(label, clk, rst_n, ante, cons)
`endif
`endif

>>> sv/lbps_pkg.sv
// Shared types, constants and helper functions of the LED blink pattern sequencer.
package lbps_pkg;

    localparam int NUM_LEDS       = 4;
    localparam int LED_IDX_W      = 2;
    localparam int TIME_WIDTH_DEF = 16;
    localparam int CFG_W          = 16;
    localparam int CFG_IDX_W      = 1;

    // Request codes.
    localparam logic [1:0] REQ_TICK  = 2'd0;
    localparam logic [1:0] REQ_WRITE = 2'd1;
    localparam logic [1:0] REQ_READ  = 2'd2;

    // Configuration register indexes.
    localparam logic [CFG_IDX_W-1:0] REG_HALF_PERIOD = 1'd0;
    localparam logic [CFG_IDX_W-1:0] REG_GAP         = 1'd1;

    localparam logic [7:0]          WRITE_LEN_OK = 8'd2;
    localparam logic [NUM_LEDS-1:0] ALL_OFF      = 4'hF;
    localparam logic [CFG_W-1:0]    HALF_RESET   = 16'd300;
    localparam logic [CFG_W-1:0]    GAP_RESET    = 16'd2000;

    typedef struct packed {
        logic [1:0] req_type;
        logic [7:0] blink_byte;
        logic [7:0] const_byte;
        logic [7:0] write_len;
    } item_word_t;

    typedef struct packed {
        logic [NUM_LEDS-1:0] led_levels;
        logic [7:0]          read_blink;
        logic [7:0]          read_const;
        logic                status;
    } result_word_t;

    typedef struct packed {
        logic [CFG_IDX_W-1:0] index;
        logic [CFG_W-1:0]     data;
    } cfg_word_t;

    // Outcome of the search for the next LED that has blinks.
    typedef struct packed {
        logic                 found;
        logic [LED_IDX_W-1:0] idx;
    } led_pick_t;

    // Blink count of one LED: once bit plus twice the twice bit.
    function automatic logic [1:0] led_blinks(input logic [7:0] pattern,
                                              input logic [LED_IDX_W-1:0] idx);
        led_blinks = {pattern[idx], pattern[{1'b1, idx}]};
    endfunction

    // One-hot bit for an LED.
    function automatic logic [NUM_LEDS-1:0] led_bit(input logic [LED_IDX_W-1:0] idx);
        led_bit = NUM_LEDS'(1) << idx;
    endfunction

    // First LED at or after 'from' whose mask bit is set.
    function automatic led_pick_t first_led(input logic [NUM_LEDS-1:0] mask,
                                            input logic [LED_IDX_W:0] from);
        led_pick_t pick;
        pick.found = 1'b0;
        pick.idx   = '0;
        for (int i = NUM_LEDS - 1; i >= 0; i--) begin
            if (mask[i] && (LED_IDX_W'(i) >= from[LED_IDX_W-1:0] || 1'b0) &&
                !from[LED_IDX_W]) begin
                pick.found = 1'b1;
                pick.idx   = LED_IDX_W'(i);
            end
        end
        first_led = pick;
    endfunction

endpackage

>>> sv/lbps_chan_if.sv
// Valid/ready channel interface carrying one word of a given payload type.
interface lbps_chan_if #(
    parameter type payload_t = logic
) ();
    logic     valid;
    logic     ready;
    payload_t payload;

    modport source (output valid, output payload, input ready);
    modport sink   (input valid, input payload, output ready);
endinterface

>>> sv/lbps_core.sv
// Pattern state, configuration registers and the per-word next-state logic.
module lbps_core #(
    parameter int TIME_WIDTH = lbps_pkg::TIME_WIDTH_DEF
) (
    input  logic                  clk,
    input  logic                  rst_n,
    lbps_chan_if.sink             cfg,
    input  logic                  accept,
    input  lbps_pkg::item_word_t  item_word,
    output lbps_pkg::result_word_t result_word
);

    localparam logic [1:0] PH_ON  = 2'd0;
    localparam logic [1:0] PH_OFF = 2'd1;
    localparam logic [1:0] PH_GAP = 2'd2;

    localparam int LW = (TIME_WIDTH > lbps_pkg::CFG_W) ? TIME_WIDTH : lbps_pkg::CFG_W;
    localparam logic [TIME_WIDTH-1:0] TICK_MAX = {TIME_WIDTH{1'b1}};

    logic [lbps_pkg::CFG_W-1:0]     half_reg, gap_reg;
    logic [7:0]                     bp_reg, bp_next;
    logic [7:0]                     cp_reg, cp_next;
    logic [1:0]                     phase_reg, phase_next;
    logic [lbps_pkg::LED_IDX_W-1:0] led_idx_reg, led_idx_next;
    logic [1:0]                     done_reg, done_next;
    logic [TIME_WIDTH-1:0]          tick_reg, tick_next;
    logic [lbps_pkg::NUM_LEDS-1:0]  pins_reg, pins_next;

    logic [LW-1:0]                  half_ext, gap_ext;
    logic [TIME_WIDTH-1:0]          half_lim, gap_lim, tick_inc;
    logic [lbps_pkg::NUM_LEDS-1:0]  mask_cur, mask_new, steady_new;
    lbps_pkg::led_pick_t            adv_next, adv_zero, adv_new, adv;
    logic                           do_adv;
    logic [2:0]                     done_inc;
    logic [7:0]                     rb, rc;
    logic                           st;

    // Configuration writes; every register accepts at once.
    assign cfg.ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            half_reg <= lbps_pkg::HALF_RESET;
            gap_reg  <= lbps_pkg::GAP_RESET;
        end
        else if (cfg.valid)
        begin
            case (cfg.payload.index)
                lbps_pkg::REG_HALF_PERIOD: half_reg <= cfg.payload.data;
                lbps_pkg::REG_GAP:         gap_reg  <= cfg.payload.data;
                default: ;
            endcase
        end
    end

    // Limits clamped to the tick counter range, and the saturating increment.
    always_comb
    begin
        half_ext = LW'(half_reg);
        gap_ext  = LW'(gap_reg);
        half_lim = (half_ext > LW'(TICK_MAX)) ? TICK_MAX : half_ext[TIME_WIDTH-1:0];
        gap_lim  = (gap_ext > LW'(TICK_MAX)) ? TICK_MAX : gap_ext[TIME_WIDTH-1:0];
        tick_inc = (tick_reg == TICK_MAX) ? tick_reg : tick_reg + TIME_WIDTH'(1);
    end

    // Candidate LEDs for the three places where the pattern moves on.
    assign mask_cur   = bp_reg[7:4] | bp_reg[3:0];
    assign mask_new   = item_word.blink_byte[7:4] | item_word.blink_byte[3:0];
    assign steady_new = item_word.const_byte[7:4];
    assign adv_next   = lbps_pkg::first_led(mask_cur, {1'b0, led_idx_reg} + 3'd1);
    assign adv_zero   = lbps_pkg::first_led(mask_cur, 3'd0);
    assign adv_new    = lbps_pkg::first_led(mask_new, 3'd0);
    assign done_inc   = {1'b0, done_reg} + 3'd1;

    // Next state for the accepted word.
    always_comb
    begin
        bp_next      = bp_reg;
        cp_next      = cp_reg;
        phase_next   = phase_reg;
        led_idx_next = led_idx_reg;
        done_next    = done_reg;
        tick_next    = tick_reg;
        pins_next    = pins_reg;
        rb           = 8'd0;
        rc           = 8'd0;
        st           = 1'b0;
        do_adv       = 1'b0;
        adv          = adv_zero;
        if (accept)
        begin
            case (item_word.req_type)
                lbps_pkg::REQ_TICK:
                begin
                    if (cp_reg[7:4] == 4'd0)
                    begin
                        tick_next = tick_inc;
                        case (phase_reg)
                            PH_ON:
                            begin
                                if (tick_inc >= half_lim)
                                begin
                                    pins_next  = lbps_pkg::ALL_OFF;
                                    phase_next = PH_OFF;
                                    tick_next  = '0;
                                end
                            end
                            PH_OFF:
                            begin
                                if (tick_inc >= half_lim)
                                begin
                                    if (done_inc <
                                        {1'b0, lbps_pkg::led_blinks(bp_reg, led_idx_reg)})
                                    begin
                                        done_next  = done_inc[1:0];
                                        phase_next = PH_ON;
                                        tick_next  = '0;
                                        pins_next  = lbps_pkg::ALL_OFF &
                                                     ~lbps_pkg::led_bit(led_idx_reg);
                                    end
                                    else
                                    begin
                                        do_adv = 1'b1;
                                        adv    = adv_next;
                                    end
                                end
                            end
                            default:
                            begin
                                if (tick_inc >= gap_lim)
                                begin
                                    do_adv = 1'b1;
                                    adv    = adv_zero;
                                end
                            end
                        endcase
                    end
                end
                lbps_pkg::REQ_WRITE:
                begin
                    if (item_word.write_len == lbps_pkg::WRITE_LEN_OK)
                    begin
                        bp_next = item_word.blink_byte;
                        cp_next = item_word.const_byte;
                        if (steady_new != 4'd0)
                        begin
                            pins_next    = lbps_pkg::ALL_OFF & ~steady_new;
                            phase_next   = PH_ON;
                            led_idx_next = '0;
                            done_next    = 2'd0;
                            tick_next    = '0;
                        end
                        else
                        begin
                            do_adv = 1'b1;
                            adv    = adv_new;
                        end
                    end
                    else
                    begin
                        st = 1'b1;
                    end
                end
                lbps_pkg::REQ_READ:
                begin
                    rb = bp_reg;
                    rc = cp_reg;
                end
                default: ;
            endcase

            // Light the chosen LED, or fall into the gap when none has blinks.
            if (do_adv)
            begin
                tick_next = '0;
                if (adv.found)
                begin
                    led_idx_next = adv.idx;
                    done_next    = 2'd0;
                    phase_next   = PH_ON;
                    pins_next    = lbps_pkg::ALL_OFF & ~lbps_pkg::led_bit(adv.idx);
                end
                else
                begin
                    phase_next = PH_GAP;
                    pins_next  = lbps_pkg::ALL_OFF;
                end
            end
        end
    end

    // Result word reflects the pin levels after this word.
    always_comb
    begin
        result_word.led_levels = pins_next;
        result_word.read_blink = rb;
        result_word.read_const = rc;
        result_word.status     = st;
    end

    // Pattern state registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            bp_reg      <= 8'd0;
            cp_reg      <= 8'd0;
            phase_reg   <= PH_ON;
            led_idx_reg <= '0;
            done_reg    <= 2'd0;
            tick_reg    <= '0;
            pins_reg    <= lbps_pkg::ALL_OFF;
        end
        else
        begin
            bp_reg      <= bp_next;
            cp_reg      <= cp_next;
            phase_reg   <= phase_next;
            led_idx_reg <= led_idx_next;
            done_reg    <= done_next;
            tick_reg    <= tick_next;
            pins_reg    <= pins_next;
        end
    end

endmodule

>>> sv/lbps_out_buf.sv
// Two-entry result buffer: an output register backed by a skid register.
module lbps_out_buf (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   push,
    input  lbps_pkg::result_word_t push_word,
    output logic                   can_push,
    lbps_chan_if.source            result
);

    logic                   head_valid_reg, head_valid_next;
    logic                   skid_valid_reg, skid_valid_next;
    lbps_pkg::result_word_t head_reg, head_next;
    lbps_pkg::result_word_t skid_reg, skid_next;
    logic                   pop;

    assign can_push       = !skid_valid_reg;
    assign pop            = head_valid_reg && result.ready;
    assign result.valid   = head_valid_reg;
    assign result.payload = head_reg;

    // Refill the head from the skid entry first, then from the new word.
    always_comb
    begin
        head_valid_next = head_valid_reg;
        skid_valid_next = skid_valid_reg;
        head_next       = head_reg;
        skid_next       = skid_reg;
        if (!head_valid_reg || pop)
        begin
            if (skid_valid_reg)
            begin
                head_next       = skid_reg;
                head_valid_next = 1'b1;
                skid_valid_next = push;
                skid_next       = push_word;
            end
            else
            begin
                head_next       = push_word;
                head_valid_next = push;
            end
        end
        else if (push)
        begin
            skid_next       = push_word;
            skid_valid_next = 1'b1;
        end
    end

    // Valid flags.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            head_valid_reg <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else
        begin
            head_valid_reg <= head_valid_next;
            skid_valid_reg <= skid_valid_next;
        end
    end

    // Payload registers.
    always_ff @(posedge clk)
    begin
        head_reg <= head_next;
        skid_reg <= skid_next;
    end

endmodule

>>> sv/led_blink_pattern_sequencer_top.sv
// Top level of the LED blink pattern sequencer.
//
//  Port    | Role   | Word fields
//  --------+--------+------------------------------------------------
//  item    | sink   | req_type, blink_byte, const_byte, write_len
//  result  | source | led_levels, read_blink, read_const, status
//  cfg     | sink   | index (0 half period, 1 gap), data (16 bit)
//
// One item word is taken per cycle while item.ready is high; its result word
// enters the output register, or the skid register when that one is occupied.
// The update is a tick counter compare and a four-LED pick. item.ready drops
// only when both result entries are full. cfg.ready is always high.
// Reset (asynchronous, active low) turns all LEDs off, clears both patterns
// and loads the half period and gap registers with 300 and 2000 ticks.
module led_blink_pattern_sequencer_top #(
    parameter int TIME_WIDTH = lbps_pkg::TIME_WIDTH_DEF
) (
    input  logic        clk,
    input  logic        rst_n,
    lbps_chan_if.sink   item,
    lbps_chan_if.source result,
    lbps_chan_if.sink   cfg
);

`include "led_blink_pattern_sequencer_top_assert.svh"

    logic                   accept;
    logic                   can_push;
    lbps_pkg::result_word_t step_word;

    // Input handshake follows the room in the result buffer.
    assign item.ready = can_push;
    assign accept     = item.valid && can_push;

    lbps_core #(
        .TIME_WIDTH (TIME_WIDTH)
    ) u_core (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg         (cfg),
        .accept      (accept),
        .item_word   (item.payload),
        .result_word (step_word)
    );

    lbps_out_buf u_out_buf (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (accept),
        .push_word (step_word),
        .can_push  (can_push),
        .result    (result)
    );

    // Every accepted word has a result waiting on the next cycle.
    `LBPS_ASSERT_NEXT(a_result_follows, clk, rst_n, accept, result.valid)
    // The input side stalls only when the output register is occupied.
    `LBPS_ASSERT_IMP(a_stall_needs_head, clk, rst_n, !item.ready, result.valid)
    // A stalled output with a full skid entry keeps the input stalled.
    `LBPS_ASSERT_NEXT(a_full_holds, clk, rst_n, !item.ready && !result.ready, !item.ready)

endmodule

>>> verif/led_blink_pattern_sequencer_top_tb.sv
// Self-checking testbench for the LED blink pattern sequencer with its own pattern predictor.
module led_blink_pattern_sequencer_top_tb;
    timeunit 1ns;
    timeprecision 1ps;

    localparam logic [1:0] REQ_RESERVED = 2'd3;
    localparam int         LONG_HOLD    = 60;
    localparam int         END_DRAIN    = 20;
    localparam int         LIMIT_CYCLES = 400000;
    localparam int         NUM_PHASES   = 6;

    typedef enum logic [1:0] {
        LIT   = 2'd0,
        DARK  = 2'd1,
        PAUSE = 2'd2
    } blink_phase_e;

    // Predicts the LED levels and read-back bytes, and matches them against the block.
    class led_sequence_tracker;
        logic [lbps_pkg::CFG_W-1:0]    half_ticks;
        logic [lbps_pkg::CFG_W-1:0]    pause_ticks;
        logic [7:0]                    blink_pat;
        logic [7:0]                    const_pat;
        blink_phase_e                  ph;
        logic [1:0]                    led;
        logic [1:0]                    blinks_done;
        logic [15:0]                   ticks;
        logic [lbps_pkg::NUM_LEDS-1:0] pins;
        lbps_pkg::result_word_t        due_words[$];
        int                            errors;

        function new();
            errors = 0;
            power_on();
        endfunction

        function void power_on();
            half_ticks  = lbps_pkg::HALF_RESET;
            pause_ticks = lbps_pkg::GAP_RESET;
            blink_pat   = 8'h00;
            const_pat   = 8'h00;
            ph          = LIT;
            led         = 2'd0;
            blinks_done = 2'd0;
            ticks       = 16'd0;
            pins        = lbps_pkg::ALL_OFF;
        endfunction

        function void set_register(logic [lbps_pkg::CFG_IDX_W-1:0] idx,
                                   logic [lbps_pkg::CFG_W-1:0] value);
            if (idx == lbps_pkg::REG_HALF_PERIOD)
                half_ticks = value;
            else
                pause_ticks = value;
        endfunction

        // One blink for the high-nibble bit, two for the low-nibble bit.
        function int unsigned blinks_for(int unsigned i);
            return int'(blink_pat[4 + i]) + 2 * int'(blink_pat[i]);
        endfunction

        function void light(int unsigned i);
            led         = i[1:0];
            blinks_done = 2'd0;
            ph          = LIT;
            ticks       = 16'd0;
            pins        = lbps_pkg::ALL_OFF & ~(4'b0001 << led);
        endfunction

        // Light the next LED that has blinks, or fall into the pause.
        function void advance_from(int unsigned from);
            for (int unsigned i = from; i < lbps_pkg::NUM_LEDS; i++) begin
                if (blinks_for(i) != 0) begin
                    light(i);
                    return;
                end
            end
            ph    = PAUSE;
            ticks = 16'd0;
            pins  = lbps_pkg::ALL_OFF;
        endfunction

        function void restart();
            if (const_pat[7:4] != 4'h0) begin
                pins        = lbps_pkg::ALL_OFF & ~const_pat[7:4];
                ph          = LIT;
                led         = 2'd0;
                blinks_done = 2'd0;
                ticks       = 16'd0;
            end
            else
                advance_from(0);
        endfunction

        function void tick();
            int unsigned next_done;
            // Steady mode holds the LEDs and ignores time.
            if (const_pat[7:4] != 4'h0)
                return;
            if (ticks != 16'hFFFF)
                ticks++;
            case (ph)
                LIT: begin
                    if (ticks >= half_ticks) begin
                        pins  = lbps_pkg::ALL_OFF;
                        ph    = DARK;
                        ticks = 16'd0;
                    end
                end
                DARK: begin
                    if (ticks >= half_ticks) begin
                        next_done = blinks_done + 1;
                        if (next_done < blinks_for(led)) begin
                            blinks_done = next_done[1:0];
                            ph          = LIT;
                            ticks       = 16'd0;
                            pins        = lbps_pkg::ALL_OFF & ~(4'b0001 << led);
                        end
                        else
                            advance_from(led + 1);
                    end
                end
                default: begin
                    if (ticks >= pause_ticks)
                        advance_from(0);
                end
            endcase
        endfunction

        // Called for every accepted item word.
        function void note_item(lbps_pkg::item_word_t w);
            lbps_pkg::result_word_t r;
            r = '0;
            case (w.req_type)
                lbps_pkg::REQ_TICK: tick();
                lbps_pkg::REQ_WRITE: begin
                    if (w.write_len == lbps_pkg::WRITE_LEN_OK) begin
                        blink_pat = w.blink_byte;
                        const_pat = w.const_byte;
                        restart();
                    end
                    else
                        r.status = 1'b1;
                end
                lbps_pkg::REQ_READ: begin
                    r.read_blink = blink_pat;
                    r.read_const = const_pat;
                end
                default: ;
            endcase
            r.led_levels = pins;
            due_words.push_back(r);
        endfunction

        task report(string msg);
            $display("%0t ns mismatch: %s", $time, msg);
            errors++;
        endtask

        // Called for every accepted result word.
        task check_result(lbps_pkg::result_word_t got);
            lbps_pkg::result_word_t want;
            if (due_words.size() == 0) begin
                report($sformatf("result word %h arrived with none outstanding", got));
                return;
            end
            want = due_words.pop_front();
            if (got.led_levels !== want.led_levels)
                report($sformatf("led_levels %h, expected %h", got.led_levels, want.led_levels));
            if (got.read_blink !== want.read_blink)
                report($sformatf("read_blink %h, expected %h", got.read_blink, want.read_blink));
            if (got.read_const !== want.read_const)
                report($sformatf("read_const %h, expected %h", got.read_const, want.read_const));
            if (got.status !== want.status)
                report($sformatf("status %b, expected %b", got.status, want.status));
        endtask
    endclass

    logic clk;
    logic rst_n;
    bit   send_calm;
    bit   recv_calm;
    bit   hold_now;
    bit   item_offered;

    led_sequence_tracker tracker = new();

    lbps_chan_if #(.payload_t(lbps_pkg::item_word_t))   item_ch ();
    lbps_chan_if #(.payload_t(lbps_pkg::result_word_t)) result_ch ();
    lbps_chan_if #(.payload_t(lbps_pkg::cfg_word_t))    cfg_ch ();

    led_blink_pattern_sequencer_top dut (
        .clk    (clk),
        .rst_n  (rst_n),
        .item   (item_ch),
        .result (result_ch),
        .cfg    (cfg_ch)
    );

    // Clock.
    initial
    begin
        clk = 1'b0;
        forever #4 clk = ~clk;
    end

    // Mostly no gap, some short ones and a few long ones.
    function automatic int pick_gap(bit calm);
        int r;
        if (calm)
            return 0;
        r = $urandom_range(0, 99);
        if (r < 55)
            return 0;
        if (r < 88)
            return $urandom_range(1, 3);
        if (r < 97)
            return $urandom_range(4, 10);
        return $urandom_range(16, 40);
    endfunction

    function automatic lbps_pkg::item_word_t make_item(logic [1:0] req, logic [7:0] blink,
                                                       logic [7:0] steady, logic [7:0] len);
        lbps_pkg::item_word_t w;
        w.req_type   = req;
        w.blink_byte = blink;
        w.const_byte = steady;
        w.write_len  = len;
        return w;
    endfunction

    // Mostly ticks so the pattern runs deep; writes are mostly well formed and in blink mode.
    function automatic lbps_pkg::item_word_t random_item();
        lbps_pkg::item_word_t w;
        int                   r;
        w.blink_byte = 8'($urandom);
        w.const_byte = 8'($urandom);
        w.write_len  = 8'($urandom);
        r = $urandom_range(0, 99);
        if (r < 84)
            w.req_type = lbps_pkg::REQ_TICK;
        else if (r < 89) begin
            w.req_type = lbps_pkg::REQ_WRITE;
            if ($urandom_range(0, 9) < 8)
                w.const_byte[7:4] = 4'h0;
            if ($urandom_range(0, 9) < 8)
                w.write_len = lbps_pkg::WRITE_LEN_OK;
            if ($urandom_range(0, 1) == 1)
                w.blink_byte = 8'h01 << $urandom_range(0, 7);
        end
        else if (r < 97)
            w.req_type = lbps_pkg::REQ_READ;
        else
            w.req_type = REQ_RESERVED;
        return w;
    endfunction

    // Offer one item word, wait for it to be taken, then maybe go idle.
    task automatic send_item(input lbps_pkg::item_word_t w);
        int n;
        item_ch.valid   <= 1'b1;
        item_ch.payload <= w;
        item_offered    = 1'b1;
        do @(posedge clk); while (item_ch.ready !== 1'b1);
        tracker.note_item(w);
        n = pick_gap(send_calm);
        if (n > 0) begin
            item_ch.valid <= 1'b0;
            item_offered  = 1'b0;
            repeat (n) @(posedge clk);
        end
    endtask

    // Stop offering and wait until every expected result word has come back.
    task automatic drain();
        if (item_offered) begin
            item_ch.valid <= 1'b0;
            item_offered  = 1'b0;
        end
        do @(posedge clk); while (tracker.due_words.size() != 0);
    endtask

    // Both registers back to back on the configuration channel.
    task automatic write_config(input logic [lbps_pkg::CFG_W-1:0] half,
                                input logic [lbps_pkg::CFG_W-1:0] gap);
        lbps_pkg::cfg_word_t c;
        c.index        = lbps_pkg::REG_HALF_PERIOD;
        c.data         = half;
        cfg_ch.valid   <= 1'b1;
        cfg_ch.payload <= c;
        do @(posedge clk); while (cfg_ch.ready !== 1'b1);
        tracker.set_register(lbps_pkg::REG_HALF_PERIOD, half);
        c.index        = lbps_pkg::REG_GAP;
        c.data         = gap;
        cfg_ch.payload <= c;
        do @(posedge clk); while (cfg_ch.ready !== 1'b1);
        tracker.set_register(lbps_pkg::REG_GAP, gap);
        cfg_ch.valid <= 1'b0;
    endtask

    // Result side: random stalls, plus one long hold on request.
    initial
    begin
        int n;
        result_ch.ready <= 1'b0;
        wait (rst_n === 1'b1);
        forever begin
            @(posedge clk);
            if (hold_now) begin
                hold_now = 1'b0;
                result_ch.ready <= 1'b0;
                repeat (LONG_HOLD) @(posedge clk);
                result_ch.ready <= 1'b1;
            end
            else begin
                n = pick_gap(recv_calm);
                if (n == 0)
                    result_ch.ready <= 1'b1;
                else begin
                    result_ch.ready <= 1'b0;
                    repeat (n) @(posedge clk);
                    result_ch.ready <= 1'b1;
                end
            end
        end
    end

    // Check every result word taken.
    always @(posedge clk)
    begin
        if (rst_n === 1'b1 && result_ch.valid === 1'b1 && result_ch.ready === 1'b1)
            tracker.check_result(result_ch.payload);
    end

    // Run limit.
    initial
    begin
        int unsigned cycles;
        for (cycles = 0; cycles < LIMIT_CYCLES; cycles++)
            @(posedge clk);
        $display("FAIL");
        $finish;
    end

    // Stimulus.
    initial
    begin
        logic [lbps_pkg::CFG_W-1:0] half_set[NUM_PHASES];
        logic [lbps_pkg::CFG_W-1:0] gap_set[NUM_PHASES];
        int                         count_set[NUM_PHASES];

        half_set  = '{16'd1, 16'd0, 16'd3, 16'd2, 16'd65535, 16'd1};
        gap_set   = '{16'd1, 16'd0, 16'd7, 16'd1, 16'd65535, 16'd65535};
        count_set = '{220, 160, 200, 160, 40, 100};

        rst_n           <= 1'b0;
        item_ch.valid   <= 1'b0;
        item_ch.payload <= '0;
        cfg_ch.valid    <= 1'b0;
        cfg_ch.payload  <= '0;
        send_calm       = 1'b0;
        recv_calm       = 1'b0;
        hold_now        = 1'b0;
        item_offered    = 1'b0;
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Reset values: reads of the cleared patterns, the ignored type, rejected lengths.
        send_item(make_item(lbps_pkg::REQ_READ, 8'h00, 8'h00, 8'h00));
        send_item(make_item(REQ_RESERVED, 8'hFF, 8'hFF, 8'hFF));
        send_item(make_item(lbps_pkg::REQ_TICK, 8'hFF, 8'hFF, 8'hFF));
        send_item(make_item(lbps_pkg::REQ_WRITE, 8'hFF, 8'hFF, 8'h00));
        send_item(make_item(lbps_pkg::REQ_WRITE, 8'hFF, 8'hFF, 8'hFF));
        send_item(make_item(lbps_pkg::REQ_WRITE, 8'hA5, 8'h0F, 8'h03));
        send_item(make_item(lbps_pkg::REQ_WRITE, 8'hA5, 8'h0F, 8'h01));
        send_item(make_item(lbps_pkg::REQ_READ, 8'h00, 8'h00, 8'h00));
        // A pattern with no blinks goes straight to the pause.
        send_item(make_item(lbps_pkg::REQ_WRITE, 8'h00, 8'h0F, lbps_pkg::WRITE_LEN_OK));
        send_item(make_item(lbps_pkg::REQ_TICK, 8'h00, 8'h00, 8'h00));
        // Steady mode, all lit and then a partial set.
        send_item(make_item(lbps_pkg::REQ_WRITE, 8'hFF, 8'hF0, lbps_pkg::WRITE_LEN_OK));
        send_item(make_item(lbps_pkg::REQ_TICK, 8'h00, 8'h00, 8'h00));
        send_item(make_item(lbps_pkg::REQ_READ, 8'h00, 8'h00, 8'h00));
        send_item(make_item(lbps_pkg::REQ_WRITE, 8'h21, 8'h50, lbps_pkg::WRITE_LEN_OK));
        drain();

        // Fast timing: LED 0 blinks three times, then a restart while LED 1 is blinking.
        write_config(16'd1, 16'd1);
        send_item(make_item(lbps_pkg::REQ_WRITE, 8'hFF, 8'h00, lbps_pkg::WRITE_LEN_OK));
        repeat (8) send_item(make_item(lbps_pkg::REQ_TICK, 8'h00, 8'h00, 8'h00));
        send_item(make_item(lbps_pkg::REQ_WRITE, 8'h80, 8'h00, lbps_pkg::WRITE_LEN_OK));
        repeat (3) send_item(make_item(lbps_pkg::REQ_TICK, 8'h00, 8'h00, 8'h00));
        send_item(make_item(lbps_pkg::REQ_READ, 8'h00, 8'h00, 8'h00));
        drain();

        // Random phases over several timing settings.
        for (int p = 0; p < NUM_PHASES; p++) begin
            send_calm = (p % 2 == 1) || (p == 2);
            recv_calm = (p == 3);
            write_config(half_set[p], gap_set[p]);
            for (int i = 0; i < count_set[p]; i++) begin
                // Long result stall while items keep coming, so the input backs up.
                if (p == 2 && i == 50)
                    hold_now = 1'b1;
                // Sender pause until everything outstanding is back.
                if (i == 100)
                    drain();
                send_item(random_item());
            end
            drain();
        end

        repeat (END_DRAIN) @(posedge clk);
        if (tracker.due_words.size() != 0)
            tracker.report($sformatf("%0d result words never arrived",
                                     tracker.due_words.size()));
        if (tracker.errors == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end

endmodule
